/* hw/rtl/srd_pkg.sv */
// shared types and constants for the sample rate derivative block
package srd_pkg;

    localparam int TIME_W  = 64;
    localparam int VAL_W   = 48;
    localparam int SCALE_W = 25;
    localparam int PROD_W  = VAL_W + SCALE_W;
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_MODE  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_SCALE = ADDR_W'(4);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000000);

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic               mode;
        logic [SCALE_W-1:0] time_scale;
    } srd_cfg_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [VAL_W-1:0]   vmag;
        logic [TIME_W-1:0]  tmag;
        logic [SCALE_W-1:0] scale;
    } srd_mdu_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             sat;
        logic [VAL_W-1:0] rate;
    } srd_mdu_rsp_t;

endpackage

/* hw/rtl/srd_in_if.sv */
// sample request channel
interface srd_in_if
    import srd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     series_start;
    logic signed [TIME_W-1:0] sample_time;
    logic signed [VAL_W-1:0]  sample_value;

    modport source (
        output valid,
        output series_start,
        output sample_time,
        output sample_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  series_start,
        input  sample_time,
        input  sample_value,
        output ready
    );
endinterface

/* hw/rtl/srd_out_if.sv */
// rate result channel
interface srd_out_if
    import srd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TIME_W-1:0] out_time;
    logic signed [VAL_W-1:0]  rate_value;
    logic                     saturated;

    modport source (
        output valid,
        output out_time,
        output rate_value,
        output saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_time,
        input  rate_value,
        input  saturated,
        output ready
    );
endinterface

/* hw/rtl/srd_cfg.sv */
// apb configuration registers for mode and time scale
module srd_cfg
    import srd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output srd_cfg_t          cfg
);

    logic               mode_reg;
    logic               mode_next;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] scale_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next  = mode_reg;
        scale_next = scale_reg;
        if (wr_en)
        begin
            case (paddr)
                ADDR_MODE:  mode_next  = pwdata[0];
                ADDR_SCALE: scale_next = pwdata[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            scale_reg <= scale_next;
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_MODE:  prdata = {{(DATA_W-1){1'b0}}, mode_reg};
            ADDR_SCALE: prdata = {{(DATA_W-SCALE_W){1'b0}}, scale_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.mode       = mode_reg;
    assign cfg.time_scale = scale_reg;

endmodule

/* hw/rtl/srd_mdu.sv */
// bit-serial multiply by time scale, then bit-serial divide by time difference
module srd_mdu
    import srd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  srd_mdu_req_t req,
    output srd_mdu_rsp_t rsp
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;
    localparam logic [1:0] M_FIX  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] rem_next;
    logic [TIME_W-1:0] dvs_reg;
    logic [TIME_W-1:0] dvs_next;
    logic [VAL_W-1:0]  vmag_reg;
    logic [VAL_W-1:0]  vmag_next;
    logic              neg_reg;
    logic              neg_next;
    logic              done_reg;
    logic              done_next;
    logic              sat_reg;
    logic              sat_next;
    logic [VAL_W-1:0]  rate_reg;
    logic [VAL_W-1:0]  rate_next;

    logic [VAL_W:0]    mul_sum;
    logic [TIME_W:0]   div_shift;
    logic [TIME_W+1:0] div_diff;
    logic              div_take;
    logic              over;
    logic [VAL_W-1:0]  mag;

    // one multiplier bit per cycle, lsb first
    assign mul_sum = {1'b0, prod_reg[PROD_W-1:SCALE_W]}
                   + (prod_reg[0] ? {1'b0, vmag_reg} : {(VAL_W+1){1'b0}});

    // restoring divide, one quotient bit per cycle
    assign div_shift = {rem_reg, prod_reg[PROD_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_reg};
    assign div_take  = !div_diff[TIME_W+1];

    // clip magnitude to the signed range
    always_comb
    begin
        if (neg_reg)
        begin
            over = (|prod_reg[PROD_W-1:VAL_W])
                || (prod_reg[VAL_W-1] && (|prod_reg[VAL_W-2:0]));
        end
        else
        begin
            over = |prod_reg[PROD_W-1:VAL_W-1];
        end
        if (over)
        begin
            mag = neg_reg ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            mag = prod_reg[VAL_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        vmag_next  = vmag_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        rate_next  = rate_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    prod_next  = {{VAL_W{1'b0}}, req.scale};
                    dvs_next   = req.tmag;
                    vmag_next  = req.vmag;
                    neg_next   = req.neg;
                    cnt_next   = CNT_W'(SCALE_W - 1);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                prod_next = {mul_sum, prod_reg[SCALE_W-1:1]};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(PROD_W - 1);
                    rem_next   = '0;
                    state_next = M_DIV;
                end
            end
            M_DIV:
            begin
                prod_next = {prod_reg[PROD_W-2:0], div_take};
                rem_next  = div_take ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = M_FIX;
                end
            end
            M_FIX:
            begin
                sat_next   = over;
                rate_next  = neg_reg ? (VAL_W'(0) - mag) : mag;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        vmag_reg <= vmag_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        rate_reg <= rate_next;
    end

    assign rsp.busy = (state_reg != M_IDLE);
    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.rate = rate_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == M_IDLE)
        else $error("mdu started while busy");

    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == M_FIX)
        else $error("mdu done without final step");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_DIV |-> rem_reg < dvs_reg)
        else $error("divider remainder out of range");

endmodule

/* hw/rtl/sample_rate_derivative_core.sv */
// sample rate derivative top level: one item accepted, worked, and handed on
// Each accepted sample yields one result. A first sample, an equal timestamp,
// a falling step in non-negative mode or an unchanged value does not use the
// bit-serial unit: a first sample gives its own value as the result, the
// others give zero. Any other sample goes through a bit-serial unit: shift-add
// to form the value change times time_scale (73 bits), then restoring division
// by the 64-bit time difference, one quotient bit per cycle, plus clipping and
// hand-off. A new sample is taken only after the previous one has reached the
// output register; that register holds its result until the sink takes it.
// For the bit-serial path rate_value is (value change * time_scale) / time
// change in the same fixed-point format as the values, truncated toward zero
// and clipped to 48 bits with saturated raised on clipping.
module sample_rate_derivative_core
    import srd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    srd_in_if.sink            in_ch,
    srd_out_if.source         out_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    srd_cfg_t     cfg;
    srd_mdu_req_t mdu_req;
    srd_mdu_rsp_t mdu_rsp;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              have_prev_reg;
    logic              have_prev_next;
    logic [TIME_W-1:0] prev_time_reg;
    logic [TIME_W-1:0] prev_time_next;
    logic [VAL_W-1:0]  prev_value_reg;
    logic [VAL_W-1:0]  prev_value_next;
    logic [TIME_W-1:0] hold_time_reg;
    logic [TIME_W-1:0] hold_time_next;
    logic [VAL_W-1:0]  res_rate_reg;
    logic [VAL_W-1:0]  res_rate_next;
    logic              res_sat_reg;
    logic              res_sat_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TIME_W-1:0] out_time_reg;
    logic [TIME_W-1:0] out_time_next;
    logic [VAL_W-1:0]  out_rate_reg;
    logic [VAL_W-1:0]  out_rate_next;
    logic              out_sat_reg;
    logic              out_sat_next;

    logic              accept;
    logic              first;
    logic              zero_res;
    logic [TIME_W:0]   tdiff;
    logic [TIME_W-1:0] tdiff_rev;
    logic              tneg;
    logic [TIME_W-1:0] tmag;
    logic [VAL_W:0]    vdiff;
    logic [VAL_W-1:0]  vdiff_rev;
    logic              vneg;
    logic [VAL_W-1:0]  vmag;
    logic              out_load;

    srd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srd_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .rsp   (mdu_rsp)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // exact differences against the previous raw sample
    assign tdiff     = {in_ch.sample_time[TIME_W-1], in_ch.sample_time}
                     - {prev_time_reg[TIME_W-1], prev_time_reg};
    assign tdiff_rev = prev_time_reg - in_ch.sample_time;
    assign tneg      = tdiff[TIME_W];
    assign tmag      = tneg ? tdiff_rev : tdiff[TIME_W-1:0];

    assign vdiff     = {in_ch.sample_value[VAL_W-1], in_ch.sample_value}
                     - {prev_value_reg[VAL_W-1], prev_value_reg};
    assign vdiff_rev = prev_value_reg - in_ch.sample_value;
    assign vneg      = vdiff[VAL_W];
    assign vmag      = vneg ? vdiff_rev : vdiff[VAL_W-1:0];

    assign first    = in_ch.series_start || !have_prev_reg;
    assign zero_res = (tdiff == '0) || (cfg.mode && vneg) || (vmag == '0);

    assign mdu_req.start = accept && !first && !zero_res;
    assign mdu_req.neg   = vneg ^ tneg;
    assign mdu_req.vmag  = vmag;
    assign mdu_req.tmag  = tmag;
    assign mdu_req.scale = cfg.time_scale;

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        have_prev_next  = have_prev_reg;
        prev_time_next  = prev_time_reg;
        prev_value_next = prev_value_reg;
        hold_time_next  = hold_time_reg;
        res_rate_next   = res_rate_reg;
        res_sat_next    = res_sat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    have_prev_next  = 1'b1;
                    prev_time_next  = in_ch.sample_time;
                    prev_value_next = in_ch.sample_value;
                    hold_time_next  = in_ch.sample_time;
                    res_sat_next    = 1'b0;
                    if (first)
                    begin
                        res_rate_next = in_ch.sample_value;
                        state_next    = S_FIN;
                    end
                    else if (zero_res)
                    begin
                        res_rate_next = '0;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (mdu_rsp.done)
                begin
                    res_rate_next = mdu_rsp.rate;
                    res_sat_next  = mdu_rsp.sat;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_time_next  = out_time_reg;
        out_rate_next  = out_rate_reg;
        out_sat_next   = out_sat_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_time_next  = hold_time_reg;
            out_rate_next  = res_rate_reg;
            out_sat_next   = res_sat_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            have_prev_reg  <= 1'b0;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            have_prev_reg  <= have_prev_next;
            prev_time_reg  <= prev_time_next;
            prev_value_reg <= prev_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_time_reg <= hold_time_next;
        res_rate_reg  <= res_rate_next;
        res_sat_reg   <= res_sat_next;
        out_time_reg  <= out_time_next;
        out_rate_reg  <= out_rate_next;
        out_sat_reg   <= out_sat_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_time   = out_time_reg;
    assign out_ch.rate_value = out_rate_reg;
    assign out_ch.saturated  = out_sat_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("request taken while previous one in flight");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result shown without a finished request");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |-> out_rate_reg == VAL_MAX || out_rate_reg == VAL_MIN)
        else $error("saturated rate not at a bound");

    a_mdu_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_rsp.busy |-> state_reg == S_WAIT)
        else $error("divider busy outside wait state");

endmodule
